FILE: design/spss_pkg.sv
// Package: shared types and constants of the shortest path search core.
`timescale 1ns / 1ps
package spss_pkg;

  localparam int NODE_COUNT        = 64;
  localparam int NODE_BITS         = 6;
  localparam int COST_BITS         = 24;
  localparam int DEF_ENTRY_COUNT   = 256;
  localparam int DEF_WEIGHT_BITS   = 16;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_HEUR  = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                 command;
    logic [NODE_BITS-1:0] owner_node;
    logic [NODE_BITS-1:0] neighbor_node;
    logic [15:0]          edge_weight;
    logic [NODE_BITS-1:0] start_node;
    logic [NODE_BITS-1:0] goal_node;
  } cmd_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] path_node;
    logic [COST_BITS-1:0] path_cost;
    logic                 found;
    logic                 last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_SEL, S_ENT, S_DST, S_UPD, S_GOAL,
    S_PATH, S_COST, S_WALK, S_WAIT, S_POP, S_EMIT, S_FAIL
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic init;
    logic scan_rst;
    logic scan_step;
    logic close_best;
    logic ent_rd;
    logic dst_rd;
    logic upd;
    logic path_init;
    logic cost_get;
    logic push;
    logic pred_rd;
    logic pred_get;
    logic pop_rd;
    logic emit;
    logic emit_fail;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic query_bad;
    logic scan_done;
    logic any_open;
    logic ent_done;
    logic ent_match;
    logic goal_closed;
    logic goal_pred;
    logic at_start;
    logic cur_pred;
    logic stack_full;
    logic pop_last;
  } sts_t;

endpackage

FILE: design/spss_ctrl.sv
// Controller: sequences commands, search rounds, relaxation and path output.
`timescale 1ns / 1ps
module spss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  spss_pkg::cmd_e command_i,
  input  spss_pkg::sts_t sts_i,
  output spss_pkg::ctl_t ctl_o,
  output logic          busy
);
  import spss_pkg::*;

  state_e state_q, state_d;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_FIND) begin
          state_d = sts_i.query_bad ? S_FAIL : S_INIT;
        end
      end
      S_INIT: state_d = S_SCAN;
      S_SCAN: if (sts_i.scan_done) state_d = S_SEL;
      S_SEL:  state_d = sts_i.any_open ? S_ENT : S_PATH;
      S_ENT:  state_d = sts_i.ent_done ? S_GOAL : S_DST;
      S_DST:  state_d = sts_i.ent_match ? S_UPD : S_ENT;
      S_UPD:  state_d = S_ENT;
      S_GOAL: state_d = sts_i.goal_closed ? S_PATH : S_SCAN;
      S_PATH: state_d = sts_i.goal_pred ? S_COST : S_FAIL;
      S_COST: state_d = S_WALK;
      S_WALK: begin
        if (sts_i.at_start) begin
          state_d = S_POP;
        end else if (!sts_i.cur_pred || sts_i.stack_full) begin
          state_d = S_FAIL;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: state_d = S_WALK;
      S_POP:  state_d = S_EMIT;
      S_EMIT: state_d = sts_i.pop_last ? S_IDLE : S_POP;
      S_FAIL: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      S_IDLE: ctl_o.load = accept;
      S_INIT: ctl_o.init = 1'b1;
      S_SCAN: ctl_o.scan_step = 1'b1;
      S_SEL:  ctl_o.close_best = sts_i.any_open;
      S_ENT:  ctl_o.ent_rd = !sts_i.ent_done;
      S_DST:  ctl_o.dst_rd = sts_i.ent_match;
      S_UPD:  ctl_o.upd = 1'b1;
      S_GOAL: ctl_o.scan_rst = !sts_i.goal_closed;
      S_PATH: ctl_o.path_init = sts_i.goal_pred;
      S_COST: ctl_o.cost_get = 1'b1;
      S_WALK: begin
        ctl_o.push    = 1'b1;
        ctl_o.pred_rd = !sts_i.at_start && sts_i.cur_pred && !sts_i.stack_full;
      end
      S_WAIT: ctl_o.pred_get = 1'b1;
      S_POP:  ctl_o.pop_rd = 1'b1;
      S_EMIT: ctl_o.emit = 1'b1;
      S_FAIL: ctl_o.emit_fail = 1'b1;
      default: ctl_o = '0;
    endcase
  end

endmodule

FILE: design/spss_dp.sv
// Datapath: adjacency, heuristic, distance, predecessor and path stores.
`timescale 1ns / 1ps
module spss_dp #(
  parameter int ENTRY_COUNT = spss_pkg::DEF_ENTRY_COUNT,
  parameter int WEIGHT_BITS = spss_pkg::DEF_WEIGHT_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spss_pkg::cmd_t cmd_i,
  input  spss_pkg::ctl_t ctl_i,
  output spss_pkg::sts_t sts_o,
  output spss_pkg::res_t result_o,
  output logic           result_valid_o
);
  import spss_pkg::*;

  localparam int EIW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW  = $clog2(ENTRY_COUNT + 1);
  localparam int SW  = COST_BITS + 9 + 1;
  localparam int NCW = NODE_BITS + 1;

  // Adjacency store
  logic [2*NODE_BITS-1:0] ent_node_mem [ENTRY_COUNT];
  logic [WEIGHT_BITS-1:0] ent_wt_mem   [ENTRY_COUNT];
  logic [CW-1:0]          ent_cnt_q, ent_idx_q;
  logic [2*NODE_BITS-1:0] ent_node_q;
  logic [WEIGHT_BITS-1:0] ent_wt_q;

  // Node stores
  logic [15:0]            heur_mem [NODE_COUNT];
  logic [COST_BITS-1:0]   dist_mem [NODE_COUNT];
  logic [NODE_BITS-1:0]   pred_mem [NODE_COUNT];
  logic [NODE_BITS-1:0]   stk_mem  [NODE_COUNT];
  logic [NODE_COUNT-1:0]  heur_vld_q, known_q, open_q, haspred_q;
  logic                   heur_act_q;
  logic [15:0]            heur_rd_q;
  logic                   heur_vld_rd_q;
  logic [COST_BITS-1:0]   dist_rd_q;
  logic [NODE_BITS-1:0]   pred_rd_q, stk_rd_q;

  // Query and search registers
  logic [NODE_BITS-1:0]   start_q, goal_q, best_q, sidx_q, cur_q;
  logic [NCW-1:0]         scan_idx_q, n_q;
  logic                   sv_q, sopen_q, any_q;
  logic [COST_BITS:0]     best_key_q;
  logic [COST_BITS-1:0]   best_dist_q, cost_q;
  res_t                   res_q;
  logic                   res_vld_q;

  logic [NODE_BITS-1:0]   ent_owner, ent_nbr;
  logic [COST_BITS:0]     key;
  logic [SW-1:0]          sum;
  logic [COST_BITS-1:0]   cand;
  logic                   take;
  logic [NODE_BITS-1:0]   dist_ra;
  logic                   dist_we;
  logic [NODE_BITS-1:0]   dist_wa;
  logic [COST_BITS-1:0]   dist_wd;

  assign ent_owner = ent_node_q[2*NODE_BITS-1:NODE_BITS];
  assign ent_nbr   = ent_node_q[NODE_BITS-1:0];

  // Selection key and relaxed cost
  assign key  = {1'b0, dist_rd_q} +
                ((heur_act_q && heur_vld_rd_q) ? (COST_BITS+1)'(heur_rd_q) : '0);
  assign sum  = SW'(best_dist_q) + SW'(ent_wt_q);
  assign cand = (sum > SW'(COST_MAX)) ? COST_MAX : sum[COST_BITS-1:0];
  assign take = !known_q[ent_nbr] || (cand < dist_rd_q);

  // Distance port selection
  always_comb begin
    dist_ra = scan_idx_q[NODE_BITS-1:0];
    if (ctl_i.dst_rd) begin
      dist_ra = ent_nbr;
    end else if (ctl_i.path_init) begin
      dist_ra = goal_q;
    end
    dist_we = ctl_i.init || (ctl_i.upd && take);
    dist_wa = ctl_i.init ? start_q : ent_nbr;
    dist_wd = ctl_i.init ? '0 : cand;
  end

  // Adjacency memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && cmd_i.command == CMD_ADD && ent_cnt_q < CW'(ENTRY_COUNT)) begin
      ent_node_mem[ent_cnt_q[EIW-1:0]] <= {cmd_i.owner_node, cmd_i.neighbor_node};
      ent_wt_mem[ent_cnt_q[EIW-1:0]]   <= WEIGHT_BITS'(cmd_i.edge_weight);
    end
    if (ctl_i.ent_rd) begin
      ent_node_q <= ent_node_mem[ent_idx_q[EIW-1:0]];
      ent_wt_q   <= ent_wt_mem[ent_idx_q[EIW-1:0]];
    end
  end

  // Node memories
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && cmd_i.command == CMD_HEUR) begin
      heur_mem[cmd_i.owner_node] <= cmd_i.edge_weight;
    end
    heur_rd_q <= heur_mem[scan_idx_q[NODE_BITS-1:0]];
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd_q <= dist_mem[dist_ra];
    if (ctl_i.upd && take) begin
      pred_mem[ent_nbr] <= best_q;
    end
    if (ctl_i.pred_rd) begin
      pred_rd_q <= pred_mem[cur_q];
    end
    if (ctl_i.push) begin
      stk_mem[n_q[NODE_BITS-1:0]] <= cur_q;
    end
    stk_rd_q <= stk_mem[NODE_BITS'(n_q - NCW'(1))];
  end

  // Control state: counts, node flags, scan and walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_cnt_q     <= '0;
      ent_idx_q     <= '0;
      heur_vld_q    <= '0;
      heur_act_q    <= 1'b0;
      heur_vld_rd_q <= 1'b0;
      known_q       <= '0;
      open_q        <= '0;
      haspred_q     <= '0;
      scan_idx_q    <= '0;
      sv_q          <= 1'b0;
      sopen_q       <= 1'b0;
      any_q         <= 1'b0;
      n_q           <= '0;
      res_vld_q     <= 1'b0;
    end else begin
      res_vld_q <= ctl_i.emit || ctl_i.emit_fail;
      heur_vld_rd_q <= heur_vld_q[scan_idx_q[NODE_BITS-1:0]];
      if (ctl_i.load) begin
        case (cmd_i.command)
          CMD_CLEAR: ent_cnt_q <= '0;
          CMD_ADD: begin
            if (ent_cnt_q < CW'(ENTRY_COUNT)) ent_cnt_q <= ent_cnt_q + CW'(1);
          end
          CMD_HEUR: begin
            heur_vld_q[cmd_i.owner_node] <= 1'b1;
            heur_act_q <= 1'b1;
          end
          default: ;
        endcase
      end
      // Start a query: only the start node is known and open
      if (ctl_i.init) begin
        known_q   <= NODE_COUNT'(1) << start_q;
        open_q    <= NODE_COUNT'(1) << start_q;
        haspred_q <= '0;
      end
      if (ctl_i.init || ctl_i.scan_rst) begin
        scan_idx_q <= '0;
        sv_q       <= 1'b0;
        any_q      <= 1'b0;
      end
      // Scan all nodes for the least key
      if (ctl_i.scan_step) begin
        sv_q <= (scan_idx_q < NCW'(NODE_COUNT));
        if (scan_idx_q < NCW'(NODE_COUNT)) begin
          sopen_q    <= open_q[scan_idx_q[NODE_BITS-1:0]];
          scan_idx_q <= scan_idx_q + NCW'(1);
        end
        if (sv_q && sopen_q && (!any_q || key < best_key_q)) begin
          any_q <= 1'b1;
        end
      end
      // Close the chosen node and rewind the entry walk
      if (ctl_i.close_best) begin
        open_q[best_q] <= 1'b0;
        ent_idx_q      <= '0;
      end
      if (ctl_i.ent_rd) ent_idx_q <= ent_idx_q + CW'(1);
      if (ctl_i.upd && take) begin
        known_q[ent_nbr]   <= 1'b1;
        haspred_q[ent_nbr] <= 1'b1;
        if (!known_q[ent_nbr]) open_q[ent_nbr] <= 1'b1;
      end
      if (ctl_i.path_init) n_q <= '0;
      if (ctl_i.push) n_q <= n_q + NCW'(1);
      if (ctl_i.pop_rd) n_q <= n_q - NCW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && cmd_i.command == CMD_FIND) begin
      start_q <= cmd_i.start_node;
      goal_q  <= cmd_i.goal_node;
    end
    if (ctl_i.scan_step && sv_q && sopen_q && (!any_q || key < best_key_q)) begin
      best_key_q  <= key;
      best_q      <= sidx_q;
      best_dist_q <= dist_rd_q;
    end
    if (ctl_i.scan_step) sidx_q <= scan_idx_q[NODE_BITS-1:0];
    if (ctl_i.path_init) cur_q <= goal_q;
    if (ctl_i.pred_get) cur_q <= pred_rd_q;
    if (ctl_i.cost_get) cost_q <= dist_rd_q;
    if (ctl_i.emit) begin
      res_q.path_node <= stk_rd_q;
      res_q.path_cost <= cost_q;
      res_q.found     <= 1'b1;
      res_q.last      <= (n_q == '0);
    end else if (ctl_i.emit_fail) begin
      res_q <= '{path_node: '0, path_cost: '0, found: 1'b0, last: 1'b1};
    end
  end

  // Status
  always_comb begin
    sts_o.query_bad   = (32'(cmd_i.start_node) >= NODE_COUNT) ||
                        (32'(cmd_i.goal_node) >= NODE_COUNT);
    sts_o.scan_done   = (scan_idx_q == NCW'(NODE_COUNT)) && !sv_q;
    sts_o.any_open    = any_q;
    sts_o.ent_done    = (ent_idx_q == ent_cnt_q);
    sts_o.ent_match   = (ent_owner == best_q);
    sts_o.goal_closed = known_q[goal_q] && !open_q[goal_q];
    sts_o.goal_pred   = haspred_q[goal_q];
    sts_o.at_start    = (cur_q == start_q);
    sts_o.cur_pred    = haspred_q[cur_q];
    sts_o.stack_full  = (n_q == NCW'(NODE_COUNT - 1));
    sts_o.pop_last    = (n_q == '0);
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

`ifndef NO_ASSERTIONS
  a_open_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q & ~known_q) == '0) else $error("open node not known");
  a_pred_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (haspred_q & ~known_q) == '0) else $error("predecessor on unknown node");
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.found |-> result_o.last && result_o.path_cost == '0)
    else $error("no-path result malformed");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NCW'(NODE_COUNT)) else $error("path stack overrun");
`endif

endmodule

FILE: design/shortest_path_search_core.sv
// Top level: shortest path search core (Dijkstra / A*) with command port.
// Clear, add-entry and set-heuristic complete without leaving idle; one command runs at a time.
// A find first initialises the search; each round then scans all nodes, selects and closes
// the least-key open node, walks every stored entry, relaxes its edges and checks the goal.
// Path output walks back from the goal to the start, then emits the nodes start first.
// Reset clears the entry count and heuristics; results cannot be stalled.
`timescale 1ns / 1ps
module shortest_path_search_core #(
  parameter int ENTRY_COUNT = spss_pkg::DEF_ENTRY_COUNT,
  parameter int WEIGHT_BITS = spss_pkg::DEF_WEIGHT_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  spss_pkg::cmd_t cmd_i,
  output spss_pkg::res_t result_o,
  output logic           result_valid_o
);
  import spss_pkg::*;

  ctl_t ctl;
  sts_t sts;

  spss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy      (busy)
  );

  spss_dp #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

FILE: verif/tb.sv
// Testbench: random and directed command stream with a path search scoreboard.
`timescale 1ns / 1ps
module tb;
  import spss_pkg::*;

  localparam int ENTRY_MAX   = DEF_ENTRY_COUNT;
  localparam int STALL_LIMIT = 200000;

  // Shadow of the block and queue of expected path items
  class path_scoreboard;
    logic [NODE_BITS-1:0] own_q[ENTRY_MAX];
    logic [NODE_BITS-1:0] nbr_q[ENTRY_MAX];
    logic [15:0]          wgt_q[ENTRY_MAX];
    int                   n_entries;
    logic [15:0]          heur[NODE_COUNT];
    bit                   astar_on;
    res_t                 pending[$];
    int                   errors;
    int                   checked;
    int                   paths_found;

    function void reset_shadow();
      n_entries = 0;
      astar_on  = 0;
      foreach (heur[i]) heur[i] = '0;
    endfunction

    // Search the shadow graph and queue the path items
    function void search_path(int src, int dst);
      logic [COST_BITS-1:0] dist_v[NODE_COUNT];
      bit                   known[NODE_COUNT];
      bit                   open_n[NODE_COUNT];
      bit                   has_pred[NODE_COUNT];
      int                   pred[NODE_COUNT];
      int                   trail[$];
      longint               key, best_key, c;
      int                   best, cur, t;
      bit                   any, ok;
      res_t                 r;
      foreach (known[i]) begin
        known[i] = 0; open_n[i] = 0; has_pred[i] = 0; dist_v[i] = '0; pred[i] = 0;
      end
      known[src] = 1;
      open_n[src] = 1;
      forever begin
        any = 0; best = 0; best_key = 0;
        for (int i = 0; i < NODE_COUNT; i++) begin
          if (!open_n[i]) continue;
          key = longint'(dist_v[i]) + (astar_on ? longint'(heur[i]) : 0);
          if (!any || key < best_key) begin
            any = 1; best_key = key; best = i;
          end
        end
        if (!any) break;
        open_n[best] = 0;
        for (int e = 0; e < n_entries; e++) begin
          if (int'(own_q[e]) != best) continue;
          t = int'(nbr_q[e]);
          c = longint'(dist_v[best]) + longint'(wgt_q[e]);
          if (c > longint'(COST_MAX)) c = longint'(COST_MAX);
          if (!known[t] || c < longint'(dist_v[t])) begin
            if (!known[t]) open_n[t] = 1;
            known[t] = 1;
            dist_v[t] = c[COST_BITS-1:0];
            pred[t] = best;
            has_pred[t] = 1;
          end
        end
        if (known[dst] && !open_n[dst]) break;
      end
      ok = 0;
      if (has_pred[dst]) begin
        cur = dst;
        while (trail.size() < NODE_COUNT) begin
          trail.push_front(cur);
          if (cur == src) begin
            ok = 1;
            break;
          end
          if (!has_pred[cur]) break;
          cur = pred[cur];
        end
      end
      if (ok) begin
        paths_found++;
        foreach (trail[k]) begin
          r.path_node = NODE_BITS'(trail[k]);
          r.path_cost = dist_v[dst];
          r.found     = 1'b1;
          r.last      = (k == trail.size() - 1);
          pending = {pending, r};
        end
      end else begin
        r = '{path_node: '0, path_cost: '0, found: 1'b0, last: 1'b1};
        pending = {pending, r};
      end
    endfunction

    // Note one accepted command
    function void note_command(cmd_t c);
      case (c.command)
        CMD_CLEAR: n_entries = 0;
        CMD_ADD: begin
          if (n_entries < ENTRY_MAX) begin
            own_q[n_entries] = c.owner_node;
            nbr_q[n_entries] = c.neighbor_node;
            wgt_q[n_entries] = c.edge_weight;
            n_entries++;
          end
        end
        CMD_HEUR: begin
          heur[c.owner_node] = c.edge_weight;
          astar_on = 1;
        end
        default: search_path(int'(c.start_node), int'(c.goal_node));
      endcase
    endfunction

    task report_error(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Compare one path item with the oldest expectation
    task check_result(res_t got);
      res_t want;
      checked++;
      if (pending.size() == 0) begin
        report_error($sformatf("unexpected item node=%0d", got.path_node));
        return;
      end
      want = pending.pop_front();
      if (got.path_node !== want.path_node)
        report_error($sformatf("path_node %0d, want %0d", got.path_node, want.path_node));
      if (got.path_cost !== want.path_cost)
        report_error($sformatf("path_cost %0d, want %0d", got.path_cost, want.path_cost));
      if (got.found !== want.found)
        report_error($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.last !== want.last)
        report_error($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  cmd_t   cmd_i = '0;
  res_t   result_o;
  logic   result_valid_o;
  int     idle_cycles = 0;
  int     n_sent = 0;
  int     n_queries = 0;
  bit     timed_out = 0;
  path_scoreboard sb = new();

  always #10 clk_i = ~clk_i;

  shortest_path_search_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // Check path items and count idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (result_valid_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold one command until the transfer, then drop start for a random gap, if any
  task automatic send_cmd(cmd_t c);
    int gap;
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
    n_sent++;
    if (c.command == CMD_FIND) n_queries++;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_add(int o, int n, int w);
    cmd_t c;
    c = cmd_t'($urandom());
    c.command = CMD_ADD;
    c.owner_node = NODE_BITS'(o);
    c.neighbor_node = NODE_BITS'(n);
    c.edge_weight = 16'(w);
    send_cmd(c);
  endtask

  task automatic send_find(int s, int g);
    cmd_t c;
    c = cmd_t'($urandom());
    c.command = CMD_FIND; c.start_node = NODE_BITS'(s); c.goal_node = NODE_BITS'(g);
    send_cmd(c);
  endtask

  task automatic send_heur(int o, int w);
    cmd_t c;
    c = cmd_t'($urandom());
    c.command = CMD_HEUR; c.owner_node = NODE_BITS'(o); c.edge_weight = 16'(w);
    send_cmd(c);
  endtask

  task automatic send_clear();
    cmd_t c;
    c = cmd_t'($urandom());
    c.command = CMD_CLEAR;
    send_cmd(c);
  endtask

  // Hold off until every path item has come
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Build a random graph mostly on nodes 0 to span and query it
  task automatic random_phase(int span, int n_edges, int n_finds);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_add($urandom_range(0, 63), $urandom_range(0, 63), $urandom());
      else
        send_add($urandom_range(0, span), $urandom_range(0, span),
                 ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40));
      if ($urandom_range(0, 7) == 0) send_heur($urandom_range(0, span), $urandom_range(0, 30));
    end
    for (int i = 0; i < n_finds; i++)
      send_find($urandom_range(0, span), $urandom_range(0, span));
  endtask

  initial begin
    sb.reset_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty graph, goal equal to start, chain, ties, heavy weights
    send_find(0, 63);
    send_add(0, 1, 5);
    send_add(1, 2, 5);
    send_add(0, 2, 10);
    send_add(2, 2, 0);
    send_add(63, 0, 16'hffff);
    send_find(0, 2);
    send_find(3, 3);
    send_find(2, 0);
    send_find(63, 2);
    for (int i = 0; i < 10; i++) send_add(i + 10, i + 11, 16'hffff);
    send_find(10, 20);
    drain();
    send_heur(1, 16'hffff);
    send_heur(63, 0);
    send_find(0, 2);
    send_clear();
    send_find(0, 2);
    drain();

    // Random adds across all nodes, then random phases on small graphs
    for (int i = 0; i < 20; i++)
      send_add($urandom_range(0, 63), $urandom_range(0, 63), $urandom());
    send_find(0, 63);
    send_find($urandom_range(0, 63), $urandom_range(0, 63));
    send_clear();
    for (int p = 0; p < 4; p++) begin
      random_phase($urandom_range(3, 12), $urandom_range(4, 12), 3);
      if (p == 2) drain();
      send_clear();
    end
    start <= 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d commands, %0d finds, %0d paths found, %0d items checked.",
             n_sent, n_queries, sb.paths_found, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0 && !timed_out)
      $display("shortest_path_search_core: match");
    else
      $display("shortest_path_search_core: mismatch");
    $finish;
  end

  // End the run if nothing moves for too long
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    timed_out = 1;
    $display("Timeout after %0d idle cycles", STALL_LIMIT);
    $display("shortest_path_search_core: mismatch");
    $finish;
  end
endmodule

FILE: filelist.f
design/spss_pkg.sv
design/spss_ctrl.sv
design/spss_dp.sv
design/shortest_path_search_core.sv
verif/tb.sv
